// ===== hw/rtl/kems_pkg.sv =====
// Shared constants, command and status codes, and sequencer states.
package kems_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int KEY_WIDTH_DEF = 16;

  localparam int ELEM_W   = 10;
  localparam int KEY_IN_W = 16;
  localparam int FILL_W   = 11;
  localparam int KEY_DEPTH = 1024;
  localparam int KEY_AW   = 10;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_KEY    = 3'd1;
  localparam logic [2:0] CMD_FILL   = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR
  } state_t;

endpackage

// ===== hw/rtl/kems_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module kems_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/keyed_extract_min_set.sv =====
// Top level: element set with extract-minimum, key table and command sequencer.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+---------------------
//  request   | in_command in_element in_key_value in_fill_count | start && !busy
//  result    | out_removed_element out_status out_set_size   | out_strobe, 1 cycle
//  config    | cfg_wdata                                     | cfg_we
//
// Append, write key, size query, remove on empty and append on full: result in the
// cycle after the request. Fill: one element store write per cycle. Remove: paced
// by the element store read port that feeds the key table read, one element
// compared per cycle.
// After reset every key table entry is cleared to zero in one pass with busy high.
// Results cannot be stalled; each is shown for one cycle only.
module keyed_extract_min_set #(
  parameter int CAPACITY  = kems_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = kems_pkg::KEY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_command,
  input  logic [kems_pkg::ELEM_W-1:0]     in_element,
  input  logic [kems_pkg::KEY_IN_W-1:0]   in_key_value,
  input  logic [kems_pkg::FILL_W-1:0]     in_fill_count,
  output logic                            out_strobe,
  output logic [kems_pkg::ELEM_W-1:0]     out_removed_element,
  output logic [1:0]                      out_status,
  output logic [$clog2(CAPACITY+1)-1:0]   out_set_size,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata
);
  import kems_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int FW    = (CNT_W > FILL_W) ? CNT_W : FILL_W;
  localparam int JW    = (AW > ELEM_W) ? AW : ELEM_W;
  localparam int CMP_W = (KEY_WIDTH > ELEM_W) ? KEY_WIDTH : ELEM_W;

  state_t state_r, state_nxt;

  logic                 cbv_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [KEY_AW-1:0]    clr_r, clr_nxt;

  logic [AW-1:0]        fill_j_r, fill_j_nxt;
  logic [ELEM_W-1:0]    excl_r, excl_nxt;

  logic [AW-1:0]        iss_r, iss_nxt;
  logic                 iss_on_r, iss_on_nxt;
  logic                 s1_v_r, s1_v_nxt;
  logic [AW-1:0]        s1_idx_r, s1_idx_nxt;
  logic                 s2_v_r, s2_v_nxt;
  logic [AW-1:0]        s2_idx_r, s2_idx_nxt;
  logic [ELEM_W-1:0]    s2_elem_r, s2_elem_nxt;

  logic [CMP_W-1:0]     best_key_r, best_key_nxt;
  logic [AW-1:0]        best_idx_r, best_idx_nxt;
  logic [ELEM_W-1:0]    best_elem_r, best_elem_nxt;

  logic                 ov_r, ov_nxt;
  logic [ELEM_W-1:0]    orem_r, orem_nxt;
  logic [1:0]           ost_r, ost_nxt;
  logic [CNT_W-1:0]     osz_r, osz_nxt;

  // element store ports
  logic                 e_we;
  logic [AW-1:0]        e_waddr, e_raddr;
  logic [ELEM_W-1:0]    e_wdata, e_rdata;
  // key table ports
  logic                 k_we;
  logic [KEY_AW-1:0]    k_waddr;
  logic [KEY_WIDTH-1:0] k_wdata, k_rdata;

  logic                 accept;
  logic [AW-1:0]        last_idx;
  logic [FW-1:0]        fill_ext, n_sat;
  logic [CNT_W-1:0]     fill_n;
  logic [JW-1:0]        j_ext, excl_ext;
  logic [CMP_W-1:0]     cur_key;

  kems_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY)) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  kems_ram #(.WIDTH(KEY_WIDTH), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (e_rdata),
    .rdata (k_rdata)
  );

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign last_idx = AW'(count_r - CNT_W'(1));

  assign fill_ext = FW'(in_fill_count);
  assign n_sat    = (fill_ext > FW'(CAPACITY)) ? FW'(CAPACITY) : fill_ext;
  assign fill_n   = (n_sat == '0) ? '0 : CNT_W'(n_sat - FW'(1));

  assign j_ext    = JW'(fill_j_r);
  assign excl_ext = JW'(excl_r);

  assign cur_key  = cbv_r ? CMP_W'(s2_elem_r) : CMP_W'(k_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      cbv_r    <= 1'b0;
      count_r  <= '0;
      clr_r    <= '0;
      iss_on_r <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) begin
        cbv_r <= cfg_wdata;
      end
      count_r  <= count_nxt;
      clr_r    <= clr_nxt;
      iss_on_r <= iss_on_nxt;
      s1_v_r   <= s1_v_nxt;
      s2_v_r   <= s2_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_j_r    <= fill_j_nxt;
    excl_r      <= excl_nxt;
    iss_r       <= iss_nxt;
    s1_idx_r    <= s1_idx_nxt;
    s2_idx_r    <= s2_idx_nxt;
    s2_elem_r   <= s2_elem_nxt;
    best_key_r  <= best_key_nxt;
    best_idx_r  <= best_idx_nxt;
    best_elem_r <= best_elem_nxt;
    orem_r      <= orem_nxt;
    ost_r       <= ost_nxt;
    osz_r       <= osz_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    clr_nxt       = clr_r;
    fill_j_nxt    = fill_j_r;
    excl_nxt      = excl_r;
    iss_nxt       = iss_r;
    iss_on_nxt    = iss_on_r;
    s1_v_nxt      = 1'b0;
    s1_idx_nxt    = s1_idx_r;
    s2_v_nxt      = 1'b0;
    s2_idx_nxt    = s2_idx_r;
    s2_elem_nxt   = s2_elem_r;
    best_key_nxt  = best_key_r;
    best_idx_nxt  = best_idx_r;
    best_elem_nxt = best_elem_r;
    ov_nxt        = 1'b0;
    orem_nxt      = '0;
    ost_nxt       = ST_OK;
    osz_nxt       = count_r;
    e_we          = 1'b0;
    e_waddr       = AW'(count_r);
    e_wdata       = in_element;
    e_raddr       = iss_r;
    k_we          = 1'b0;
    k_waddr       = in_element;
    k_wdata       = KEY_WIDTH'(in_key_value);

    unique case (state_r)
      S_CLEAR: begin
        k_we    = 1'b1;
        k_waddr = clr_r;
        k_wdata = '0;
        clr_nxt = clr_r + KEY_AW'(1);
        if (clr_r == KEY_AW'(KEY_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_APPEND: begin
              ov_nxt = 1'b1;
              if (count_r >= CNT_W'(CAPACITY)) begin
                ost_nxt = ST_FULL;
              end else begin
                e_we      = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                osz_nxt   = count_r + CNT_W'(1);
              end
            end
            CMD_KEY: begin
              k_we   = 1'b1;
              ov_nxt = 1'b1;
            end
            CMD_FILL: begin
              count_nxt  = fill_n;
              excl_nxt   = in_element;
              fill_j_nxt = '0;
              if (fill_n == '0) begin
                ov_nxt  = 1'b1;
                osz_nxt = '0;
              end else begin
                state_nxt = S_FILL;
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_EMPTY;
              end else begin
                state_nxt  = S_SCAN;
                iss_nxt    = '0;
                iss_on_nxt = 1'b1;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end

      S_FILL: begin
        // skip the excluded index by shifting later values up by one
        e_we       = 1'b1;
        e_waddr    = fill_j_r;
        e_wdata    = ELEM_W'((j_ext < excl_ext) ? j_ext : j_ext + JW'(1));
        fill_j_nxt = fill_j_r + AW'(1);
        if (fill_j_r == last_idx) begin
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
        end
      end

      S_SCAN: begin
        // issue one store read per cycle; key read follows in the next cycle
        e_raddr = iss_r;
        if (iss_on_r) begin
          s1_v_nxt   = 1'b1;
          s1_idx_nxt = iss_r;
          if (iss_r == last_idx) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_nxt = iss_r + AW'(1);
          end
        end
        s2_v_nxt    = s1_v_r;
        s2_idx_nxt  = s1_idx_r;
        s2_elem_nxt = e_rdata;
        if (s2_v_r) begin
          // strict less keeps the first of equal minima
          if (s2_idx_r == '0 || cur_key < best_key_r) begin
            best_key_nxt  = cur_key;
            best_idx_nxt  = s2_idx_r;
            best_elem_nxt = s2_elem_r;
          end
          if (s2_idx_r == last_idx) begin
            state_nxt = S_MOVE_RD;
          end
        end
      end

      S_MOVE_RD: begin
        e_raddr   = last_idx;
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        // move the last element into the hole
        e_we      = 1'b1;
        e_waddr   = best_idx_r;
        e_wdata   = e_rdata;
        count_nxt = count_r - CNT_W'(1);
        ov_nxt    = 1'b1;
        orem_nxt  = best_elem_r;
        osz_nxt   = count_r - CNT_W'(1);
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_strobe          = ov_r;
  assign out_removed_element = orem_r;
  assign out_status          = ost_r;
  assign out_set_size        = osz_r;

endmodule

// ===== hw/rtl/kems_checker.sv =====
// Port-level checker for the extract-min set, bound to the top level.
module kems_checker #(
  parameter int CAPACITY = kems_pkg::CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [kems_pkg::ELEM_W-1:0]   out_removed_element,
  input logic [1:0]                    out_status,
  input logic [$clog2(CAPACITY+1)-1:0] out_set_size
);
  import kems_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // an accepted request either keeps the block busy or answers next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted request produced neither busy nor a result");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_EMPTY) |->
      (out_removed_element == '0 && out_set_size == '0))
    else $error("empty remove reported a nonzero element or size");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FULL) |->
      (out_set_size == CNT_W'(CAPACITY) && out_removed_element == '0))
    else $error("full append reported wrong size or element");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_set_size <= CNT_W'(CAPACITY) &&
                    (out_status == ST_OK || out_status == ST_EMPTY ||
                     out_status == ST_FULL)))
    else $error("result size above capacity or bad status");

endmodule

bind keyed_extract_min_set kems_checker #(.CAPACITY(CAPACITY)) u_kems_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_strobe          (out_strobe),
  .out_removed_element (out_removed_element),
  .out_status          (out_status),
  .out_set_size        (out_set_size)
);
